// ----- hdl/lzdec_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lzdec_pkg
// Shared constants and types for the LZSS 4 KiB window decoder.
// ----------------------------------------------------------------------------
package lzdec_pkg;

  localparam int WINDOW_SIZE = 4096;
  localparam int WIN_AW      = $clog2(WINDOW_SIZE);
  localparam int LEN_BIAS    = 3;
  // remaining-byte counter: holds match length minus one (2..17)
  localparam int CNT_W       = 5;
  localparam int FLAG_BITS   = 8;
  localparam int BLEFT_W     = 4;

  typedef logic [WIN_AW-1:0] win_addr_t;

  typedef struct packed {
    logic [7:0] data;
    logic       err;
    logic       last;
  } res_t;

  typedef struct packed {
    logic       en;
    logic [7:0] data;
  } hist_wr_t;

endpackage : lzdec_pkg
`default_nettype wire

// ----- hdl/lzdec_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lzdec_in_if / lzdec_out_if
// Valid/ready channels for compressed input words and decoded result words.
// ----------------------------------------------------------------------------
interface lzdec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       segment_end;

  modport source (output valid, output in_byte, output segment_end, input ready);
  modport sink   (input valid, input in_byte, input segment_end, output ready);
endinterface : lzdec_in_if

interface lzdec_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_error;
  logic       run_last;

  modport source (output valid, output out_byte, output is_error, output run_last,
                  input ready);
  modport sink   (input valid, input out_byte, input is_error, input run_last,
                  output ready);
endinterface : lzdec_out_if
`default_nettype wire

// ----- hdl/lzdec_hist.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lzdec_hist
// 4 KiB history RAM. Writes go to the fill position; a fill pointer plus a
// wrap flag stand in for clearing, and a same-cycle write is forwarded.
// ----------------------------------------------------------------------------
module lzdec_hist
  import lzdec_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      clr,
  input  wire win_addr_t wpos,
  input  wire hist_wr_t  wr,
  input  wire logic      rd_en,
  input  wire win_addr_t rd_addr,
  output      logic [7:0] rd_data
);

  logic [7:0] mem [WINDOW_SIZE];
  logic [7:0] q_r;
  logic [7:0] fwd_r;
  logic       hit_r;
  logic       vld_r;
  logic       full_r;
  logic       full_nxt;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wpos] <= wr.data;
    end
    if (rd_en) begin
      q_r <= mem[rd_addr];
    end
  end

  // entries below the fill position (or all, once wrapped) hold this segment's data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      hit_r <= wr.en && (rd_addr == wpos);
      vld_r <= full_r || (rd_addr < wpos);
    end
    if (wr.en) begin
      fwd_r <= wr.data;
    end
  end

  always_comb begin
    full_nxt = full_r;
    if (clr) begin
      full_nxt = 1'b0;
    end else if (wr.en && (wpos == win_addr_t'(WINDOW_SIZE - 1))) begin
      full_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else begin
      full_r <= full_nxt;
    end
  end

  assign rd_data = hit_r ? fwd_r : (vld_r ? q_r : 8'h00);

endmodule : lzdec_hist
`default_nettype wire

// ----- hdl/lzdec_oq.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lzdec_oq
// Two-word result queue that drives the output channel.
// ----------------------------------------------------------------------------
module lzdec_oq
  import lzdec_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire res_t  push_word,
  output      logic  pop,
  output      logic [1:0] occ,
  lzdec_out_if.source out_chan
);

  res_t       ent [2];
  logic       rptr_r;
  logic       wptr_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;

  assign out_chan.valid    = (cnt_r != 2'd0);
  assign out_chan.out_byte = ent[rptr_r].data;
  assign out_chan.is_error = ent[rptr_r].err;
  assign out_chan.run_last = ent[rptr_r].last;
  assign pop = out_chan.valid && out_chan.ready;
  assign occ = cnt_r;

  always_comb begin
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wptr_r] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rptr_r <= 1'b0;
      wptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) begin
        wptr_r <= ~wptr_r;
      end
      if (pop) begin
        rptr_r <= ~rptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule : lzdec_oq
`default_nettype wire

// ----- hdl/lzss_4k_window_decoder.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lzss_4k_window_decoder
// LZSS segment decoder with a 4 KiB history, one compressed byte per word.
// ----------------------------------------------------------------------------
// A flag byte or the first byte of a match code is taken and gives nothing;
// a literal is taken and gives one word. The second code byte starts a copy
// of 3..18 bytes that streams out of the history RAM at one byte per cycle,
// while the result queue has room, through its single read port, and no new
// input word is taken until the last copied byte has left the read pipeline.
// Overlapping copies are forwarded around the RAM. The history is cleared
// logically at each segment end by a fill pointer, so there is no clearing
// pass after reset. A segment that ends on the first byte of a match code
// yields a single error word.
module lzss_4k_window_decoder
  import lzdec_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  lzdec_in_if.sink    in_chan,
  lzdec_out_if.source out_chan
);

  // control registers
  logic [7:0]         flag_r,    flag_nxt;
  logic [BLEFT_W-1:0] bleft_r,   bleft_nxt;
  logic               pend_r,    pend_nxt;
  logic [7:0]         chigh_r,   chigh_nxt;
  win_addr_t          wp_r,      wp_nxt;
  logic               busy_r,    busy_nxt;
  win_addr_t          src_r,     src_nxt;
  logic [CNT_W-1:0]   cnt_r,     cnt_nxt;
  logic               segend_r,  segend_nxt;
  logic               infl_r,    infl_nxt;
  logic               last_r,    last_nxt;

  logic        accept;
  logic        issue;
  logic        lit_wr;
  logic        clr;
  logic        pop;
  logic [1:0]  occ;
  logic [2:0]  inuse;
  logic        push;
  res_t        push_word;
  hist_wr_t    hwr;
  logic [7:0]  rd_data;
  logic [15:0] code;

  assign inuse = {1'b0, occ} + {2'b00, infl_r} - {2'b00, pop};
  assign issue = busy_r && (inuse < 3'd2);

  assign in_chan.ready = !busy_r && !infl_r && (occ != 2'd2);
  assign accept = in_chan.valid && in_chan.ready;
  assign code   = {chigh_r, in_chan.in_byte};

  always_comb begin
    flag_nxt   = flag_r;
    bleft_nxt  = bleft_r;
    pend_nxt   = pend_r;
    chigh_nxt  = chigh_r;
    wp_nxt     = wp_r;
    busy_nxt   = busy_r;
    src_nxt    = src_r;
    cnt_nxt    = cnt_r;
    segend_nxt = segend_r;
    infl_nxt   = issue;
    last_nxt   = last_r;
    lit_wr     = 1'b0;
    clr        = 1'b0;
    push       = 1'b0;
    push_word  = '{data: 8'h00, err: 1'b0, last: 1'b1};

    // copy read issue
    if (issue) begin
      src_nxt  = src_r + win_addr_t'(1);
      cnt_nxt  = cnt_r - CNT_W'(1);
      last_nxt = (cnt_r == '0);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end
    end

    // copy data stage
    if (infl_r) begin
      push      = 1'b1;
      push_word = '{data: rd_data, err: 1'b0, last: last_r};
      wp_nxt    = wp_r + win_addr_t'(1);
      if (last_r && segend_r) begin
        wp_nxt     = '0;
        clr        = 1'b1;
        segend_nxt = 1'b0;
      end
    end

    if (accept) begin
      priority if (pend_r) begin
        pend_nxt   = 1'b0;
        busy_nxt   = 1'b1;
        src_nxt    = wp_r + code[WIN_AW-1:0];
        cnt_nxt    = CNT_W'(code[15:WIN_AW]) + CNT_W'(LEN_BIAS - 1);
        segend_nxt = in_chan.segment_end;
      end else if (bleft_r == '0) begin
        flag_nxt  = in_chan.in_byte;
        bleft_nxt = BLEFT_W'(FLAG_BITS);
      end else begin
        flag_nxt  = {flag_r[6:0], 1'b0};
        bleft_nxt = bleft_r - BLEFT_W'(1);
        if (flag_r[7]) begin
          lit_wr    = 1'b1;
          push      = 1'b1;
          push_word = '{data: in_chan.in_byte, err: 1'b0, last: 1'b1};
          wp_nxt    = wp_r + win_addr_t'(1);
        end else begin
          chigh_nxt = in_chan.in_byte;
          pend_nxt  = 1'b1;
          if (in_chan.segment_end) begin
            push      = 1'b1;
            push_word = '{data: 8'h00, err: 1'b1, last: 1'b1};
          end
        end
      end
      // segment end: token state resets now; a pending copy resets the window later
      if (in_chan.segment_end) begin
        flag_nxt  = '0;
        bleft_nxt = '0;
        pend_nxt  = 1'b0;
        chigh_nxt = '0;
        if (!pend_r) begin
          wp_nxt = '0;
          clr    = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r   <= '0;
      bleft_r  <= '0;
      pend_r   <= 1'b0;
      chigh_r  <= '0;
      wp_r     <= '0;
      busy_r   <= 1'b0;
      src_r    <= '0;
      cnt_r    <= '0;
      segend_r <= 1'b0;
      infl_r   <= 1'b0;
      last_r   <= 1'b0;
    end else begin
      flag_r   <= flag_nxt;
      bleft_r  <= bleft_nxt;
      pend_r   <= pend_nxt;
      chigh_r  <= chigh_nxt;
      wp_r     <= wp_nxt;
      busy_r   <= busy_nxt;
      src_r    <= src_nxt;
      cnt_r    <= cnt_nxt;
      segend_r <= segend_nxt;
      infl_r   <= infl_nxt;
      last_r   <= last_nxt;
    end
  end

  assign hwr.en   = lit_wr || infl_r;
  assign hwr.data = lit_wr ? in_chan.in_byte : rd_data;

  lzdec_hist u_hist (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (clr),
    .wpos    (wp_r),
    .wr      (hwr),
    .rd_en   (issue),
    .rd_addr (src_r),
    .rd_data (rd_data)
  );

  lzdec_oq u_oq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .occ       (occ),
    .out_chan  (out_chan)
  );

`ifndef SYNTHESIS
  // read credit must keep the queue from overflowing
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (occ != 2'd2) || pop)
    else $error("result queue overflow");

  a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
    occ != 2'd3)
    else $error("result queue count out of range");

  // one RAM write per cycle: literal and copy data never coincide
  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(lit_wr && infl_r))
    else $error("literal written during copy");

  a_seg_wp: assert property (@(posedge clk) disable iff (!rst_n)
    (infl_r && last_r && segend_r) |=> (wp_r == '0))
    else $error("write pointer not cleared at segment end");

  a_busy_pend: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !pend_r)
    else $error("code byte pending during copy");
`endif

endmodule : lzss_4k_window_decoder
`default_nettype wire

// ----- verif/lzdec_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lzdec_checker
// Passive scoreboard for the LZSS decoder: tracks every compressed word taken
// on the input channel, predicts the decoded words and compares each word
// leaving the result channel against the oldest prediction.
// ----------------------------------------------------------------------------
module lzdec_checker
  import lzdec_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_seg_end,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte,
  input  logic       out_is_error,
  input  logic       out_run_last,
  output int         mismatches,
  output int         pending,
  output int         words_out,
  output int         error_words
);

  logic [7:0]           hist [WINDOW_SIZE];
  win_addr_t            wr_ptr;
  logic [FLAG_BITS-1:0] flags;
  logic [BLEFT_W-1:0]   flags_left;
  logic                 code_pend;
  logic [7:0]           code_hi;
  res_t                 decoded_q [$];
  res_t                 want;

  task automatic clear_history();
    for (int i = 0; i < WINDOW_SIZE; i++) hist[i] = 8'h00;
    wr_ptr     = '0;
    flags      = '0;
    flags_left = '0;
    code_pend  = 1'b0;
    code_hi    = 8'h00;
  endtask

  task automatic push_byte(input logic [7:0] v);
    res_t r;
    r.data = v;
    r.err  = 1'b0;
    r.last = 1'b0;
    hist[wr_ptr] = v;
    wr_ptr = wr_ptr + 1'b1;
    decoded_q = {decoded_q, r};
  endtask

  task automatic decode_word(input logic [7:0] b, input logic seg_end);
    logic [15:0] code;
    win_addr_t   src;
    int          len;
    int          n;
    res_t        r;
    n = 0;
    if (code_pend) begin
      code      = {code_hi, b};
      len       = int'(code[15:12]) + LEN_BIAS;
      src       = wr_ptr + code[WIN_AW-1:0];
      code_pend = 1'b0;
      // byte by byte, so an overlapping source sees the bytes just written
      for (int i = 0; i < len; i++) begin
        push_byte(hist[src]);
        src = src + 1'b1;
      end
      n = len;
    end else if (flags_left == 0) begin
      flags      = b;
      flags_left = BLEFT_W'(FLAG_BITS);
    end else begin
      flags_left = flags_left - 1'b1;
      if (flags[FLAG_BITS-1]) begin
        push_byte(b);
        n = 1;
      end else begin
        code_hi   = b;
        code_pend = 1'b1;
        // segment cut off inside a match code
        if (seg_end) begin
          r.data = 8'h00;
          r.err  = 1'b1;
          r.last = 1'b0;
          decoded_q = {decoded_q, r};
          n = 1;
        end
      end
      flags = flags << 1;
    end
    if (n > 0) begin
      r = decoded_q.pop_back();
      r.last = 1'b1;
      decoded_q = {decoded_q, r};
    end
    if (seg_end) clear_history();
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_history();
      decoded_q.delete();
      mismatches  = 0;
      words_out   = 0;
      error_words = 0;
    end else begin
      if (in_valid && in_ready) decode_word(in_byte, in_seg_end);
      if (out_valid && out_ready) begin
        words_out++;
        if (out_is_error) error_words++;
        if (decoded_q.size() == 0) begin
          mismatches++;
          $display("%0t chk: unexpected word, out_byte=%02h is_error=%0b run_last=%0b",
                   $time, out_byte, out_is_error, out_run_last);
        end else begin
          want = decoded_q.pop_front();
          if (out_byte !== want.data) begin
            mismatches++;
            $display("%0t chk: out_byte expected %02h, got %02h", $time, want.data, out_byte);
          end
          if (out_is_error !== want.err) begin
            mismatches++;
            $display("%0t chk: is_error expected %0b, got %0b", $time, want.err, out_is_error);
          end
          if (out_run_last !== want.last) begin
            mismatches++;
            $display("%0t chk: run_last expected %0b, got %0b", $time, want.last, out_run_last);
          end
        end
      end
    end
    pending = decoded_q.size();
  end

endmodule : lzdec_checker

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the LZSS 4 KiB window decoder: directed segments
// for literals, shortest and longest matches, overlapping copies and every
// way a segment can end, then random segments with random gaps on the input
// and random stalls on the output. Checking lives in lzdec_checker.
// ----------------------------------------------------------------------------
module tb;

  localparam int RANDOM_WORDS = 180;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       src_valid  = 1'b0;
  logic [7:0] src_byte   = 8'h00;
  logic       src_end    = 1'b0;
  logic       sink_ready = 1'b0;
  bit         no_stall   = 1'b0;
  int         rdy_hold   = 0;
  int         words_in   = 0;
  int         segments   = 0;
  int         mismatches;
  int         pending;
  int         words_out;
  int         error_words;

  lzdec_in_if  in_chan ();
  lzdec_out_if out_chan ();

  assign in_chan.valid       = src_valid;
  assign in_chan.in_byte     = src_byte;
  assign in_chan.segment_end = src_end;
  assign out_chan.ready      = sink_ready;

  lzss_4k_window_decoder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  lzdec_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_chan.valid),
    .in_ready     (in_chan.ready),
    .in_byte      (in_chan.in_byte),
    .in_seg_end   (in_chan.segment_end),
    .out_valid    (out_chan.valid),
    .out_ready    (out_chan.ready),
    .out_byte     (out_chan.out_byte),
    .out_is_error (out_chan.is_error),
    .out_run_last (out_chan.run_last),
    .mismatches   (mismatches),
    .pending      (pending),
    .words_out    (words_out),
    .error_words  (error_words)
  );

  always #1 clk = ~clk;

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  always @(negedge clk) begin
    if (no_stall) begin
      sink_ready <= 1'b1;
      rdy_hold = 0;
    end else if (rdy_hold > 0) begin
      rdy_hold--;
    end else if (sink_ready) begin
      sink_ready <= 1'b0;
      rdy_hold = pick_gap();
    end else begin
      sink_ready <= 1'b1;
      rdy_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 12);
    end
  end

  // returns at the falling edge after the word was taken
  task automatic send_word(input logic [7:0] b, input logic seg_end);
    int gap;
    gap = no_stall ? 0 : pick_gap();
    if (gap > 0) begin
      src_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    src_valid = 1'b1;
    src_byte  = b;
    src_end   = seg_end;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
    words_in++;
    if (seg_end) segments++;
  endtask

  // offset that points k bytes back from the write position
  function automatic int WINDOW_NEG(input int k);
    return (4096 - k) & 12'hFFF;
  endfunction

  // Tracks the decoder phase so that flag, literal and code bytes land where
  // they mean something; a few noise bytes knock the phase around.
  task automatic random_segment(input int n_words);
    logic [7:0]  b;
    logic [7:0]  fl;
    logic [3:0]  left;
    logic        pend;
    logic [7:0]  lo_next;
    logic [11:0] ofs;
    int          r;
    left    = '0;
    fl      = '0;
    pend    = 1'b0;
    lo_next = '0;
    for (int i = 0; i < n_words; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        b = 8'($urandom);
      end else if (pend) begin
        b = lo_next;
      end else if (left == 0) begin
        r = $urandom_range(0, 9);
        b = (r < 2) ? 8'h00 : (r < 4) ? 8'hFF : 8'($urandom);
      end else if (fl[7]) begin
        b = 8'($urandom);
      end else begin
        r = $urandom_range(0, 9);
        if (r < 5)      ofs = 12'(WINDOW_NEG(($urandom_range(1, 32))));
        else if (r < 7) ofs = 12'(WINDOW_NEG(($urandom_range(1, 512))));
        else            ofs = 12'($urandom);
        b       = {4'($urandom), ofs[11:8]};
        lo_next = ofs[7:0];
      end
      if (pend) begin
        pend = 1'b0;
      end else if (left == 0) begin
        fl   = b;
        left = 4'd8;
      end else begin
        if (!fl[7]) pend = 1'b1;
        fl   = fl << 1;
        left = left - 1'b1;
      end
      send_word(b, i == n_words - 1);
    end
  endtask

  initial begin
    int r;
    int seg_len;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // literals 00/FF, longest match repeating the last byte, shortest match
    // overlapping its own output, segment ends on a second code byte
    send_word(8'hC0, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h0F, 1'b0);
    send_word(8'hFE, 1'b1);
    // matches reading ahead of the write position see a cleared history;
    // segment ends on a first code byte
    send_word(8'h00, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'h28, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'hAB, 1'b1);
    // segment ends on a flag byte
    send_word(8'hA5, 1'b1);
    // literal, overlapping match, segment ends on a literal
    send_word(8'hBF, 1'b0);
    send_word(8'h5A, 1'b0);
    send_word(8'h7F, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h01, 1'b1);

    while (words_in < 19 + RANDOM_WORDS) begin
      r = $urandom_range(0, 99);
      if (r < 10)      seg_len = $urandom_range(1, 4);
      else if (r < 85) seg_len = $urandom_range(5, 30);
      else             seg_len = $urandom_range(31, 80);
      no_stall = ($urandom_range(0, 4) == 0);
      random_segment(seg_len);
    end
    src_valid = 1'b0;
    no_stall  = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);

    $display("summary: %0d compressed words in %0d segments, %0d decoded words out",
             words_in, segments, words_out);
    $display("summary: %0d truncated-code error words, %0d mismatches",
             error_words, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: FAIL");
    $finish;
  end

endmodule : tb
